// ----- hdl/csdc_pkg.sv -----
// ----------------------------------------------------------------------------
// csdc_pkg
// Shared types and constants for the cross-sequence dominance count unit.
// ----------------------------------------------------------------------------
`default_nettype none

package csdc_pkg;

  // history geometry
  localparam int HISTORY_DEPTH = 1024;
  localparam int VALUE_BITS    = 31;
  localparam int ADDR_W        = $clog2(HISTORY_DEPTH);
  localparam int COUNT_W       = ADDR_W + 1;

  // result field widths
  localparam int SCORE_W   = 19;
  localparam int ROUNDS_W  = 11;
  localparam logic [SCORE_W-1:0] SCORE_MAX = {SCORE_W{1'b1}};

  typedef logic [VALUE_BITS-1:0] value_t;
  typedef logic [ADDR_W-1:0]     addr_t;
  typedef logic [COUNT_W-1:0]    count_t;
  typedef logic [SCORE_W-1:0]    score_t;
  typedef logic [SCORE_W:0]      score_sum_t;
  typedef logic [ROUNDS_W-1:0]   rounds_t;

  // input item
  typedef struct packed {
    logic [30:0] first_value;
    logic [30:0] second_value;
    logic        last_round;
  } in_item_t;

  // result item
  typedef struct packed {
    logic [18:0] first_score;
    logic [18:0] second_score;
    logic [10:0] rounds_seen;
    logic        history_full;
    logic        final_res;
  } out_item_t;

  // scan request from the control to the scanner
  typedef struct packed {
    logic   start;
    count_t count;
  } scan_req_t;

  // scan status back to the control
  typedef struct packed {
    logic   done;
    count_t first_gain;
    count_t second_gain;
  } scan_stat_t;

endpackage

`default_nettype wire

// ----- hdl/csdc_ram.sv -----
// ----------------------------------------------------------------------------
// csdc_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module csdc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ----- hdl/csdc_scan.sv -----
// ----------------------------------------------------------------------------
// csdc_scan
// Walks the stored history one entry a cycle and counts, for each sequence,
// the stored entries of the other sequence strictly below its current value.
// ----------------------------------------------------------------------------
`default_nettype none

module csdc_scan (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire csdc_pkg::scan_req_t    req,
  input  wire csdc_pkg::value_t       first_value,
  input  wire csdc_pkg::value_t       second_value,
  input  wire csdc_pkg::value_t       first_rd_data,
  input  wire csdc_pkg::value_t       second_rd_data,
  output logic                        rd_en,
  output csdc_pkg::addr_t             rd_addr,
  output csdc_pkg::scan_stat_t        stat
);

  logic               busy;
  logic               pending;
  csdc_pkg::count_t   count;
  csdc_pkg::count_t   issue_idx;
  csdc_pkg::count_t   first_gain;
  csdc_pkg::count_t   second_gain;

  // read issue while entries remain
  assign rd_en   = busy && (issue_idx < count);
  assign rd_addr = issue_idx[csdc_pkg::ADDR_W-1:0];

  // control: busy flag and read-data tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b0;
      pending <= 1'b0;
    end else begin
      pending <= rd_en;
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && !rd_en && !pending) begin
        busy <= 1'b0;
      end
    end
  end

  // address counter and gain counters
  always_ff @(posedge clk) begin
    if (req.start) begin
      count       <= req.count;
      issue_idx   <= '0;
      first_gain  <= '0;
      second_gain <= '0;
    end else begin
      if (rd_en) begin
        issue_idx <= issue_idx + csdc_pkg::count_t'(1);
      end
      if (pending) begin
        if (second_rd_data < first_value) begin
          first_gain <= first_gain + csdc_pkg::count_t'(1);
        end
        if (first_rd_data < second_value) begin
          second_gain <= second_gain + csdc_pkg::count_t'(1);
        end
      end
    end
  end

  // status back to the control
  assign stat = {busy && !req.start && !rd_en && !pending, first_gain, second_gain};

endmodule

`default_nettype wire

// ----- hdl/cross_sequence_dominance_count_unit.sv -----
// ----------------------------------------------------------------------------
// cross_sequence_dominance_count_unit
// Scores two sequences round by round against their stored history.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid / in_stall / in_item carries one round: a value of
//   each sequence and a last-round mark. Output channel out_valid / out_stall
//   / out_item returns one result per round: both running scores, the round
//   count, the history-full flag and the final-result mark.
//   Each round reads every stored earlier round from the two history RAMs,
//   one entry per cycle through a single read port each. A round passes
//   from acceptance through the scan state to the update state, where its
//   result is written to the output register.
//   in_stall is high while a round is in work, so a new round is accepted
//   only after the previous round has left the update state.
//   The result sits in an output register; the next round may be accepted
//   and scanned while it waits. If out_stall is still high when the next
//   round is scored, that round waits in its update step until the register
//   frees, and in_stall stays high meanwhile.
//   Reset clears the round count, both scores and the output valid. The
//   history RAMs are not cleared; only entries written in the current game
//   are read. After a round marked last, count and scores clear.
// ----------------------------------------------------------------------------
`default_nettype none

module cross_sequence_dominance_count_unit (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire csdc_pkg::in_item_t   in_item,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output csdc_pkg::out_item_t       out_item
);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SCAN   = 3'b010,
    S_UPDATE = 3'b100
  } state_t;

  state_t               state;
  state_t               state_next;
  csdc_pkg::value_t     first_value;
  csdc_pkg::value_t     second_value;
  logic                 last_round;
  csdc_pkg::count_t     stored_count;
  csdc_pkg::score_t     first_total;
  csdc_pkg::score_t     second_total;

  logic                 in_accept;
  logic                 commit;
  logic                 full;
  csdc_pkg::count_t     count_next;
  csdc_pkg::score_sum_t first_sum;
  csdc_pkg::score_sum_t second_sum;
  csdc_pkg::score_t     first_total_next;
  csdc_pkg::score_t     second_total_next;

  csdc_pkg::scan_req_t  scan_req;
  csdc_pkg::scan_stat_t scan_stat;
  logic                 rd_en;
  csdc_pkg::addr_t      rd_addr;
  csdc_pkg::value_t     first_rd_data;
  csdc_pkg::value_t     second_rd_data;
  logic                 wr_en;

  assign in_stall  = (state != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign commit    = (state == S_UPDATE) && (!out_valid || !out_stall);

  // sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_accept) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_stat.done) begin
          state_next = S_UPDATE;
        end
      end
      S_UPDATE: begin
        if (commit) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // round capture
  always_ff @(posedge clk) begin
    if (in_accept) begin
      first_value  <= in_item.first_value[csdc_pkg::VALUE_BITS-1:0];
      second_value <= in_item.second_value[csdc_pkg::VALUE_BITS-1:0];
      last_round   <= in_item.last_round;
    end
  end

  // scanner over the stored history
  assign scan_req = {in_accept, stored_count};

  csdc_scan u_scan (
    .clk            (clk),
    .rst            (rst),
    .req            (scan_req),
    .first_value    (first_value),
    .second_value   (second_value),
    .first_rd_data  (first_rd_data),
    .second_rd_data (second_rd_data),
    .rd_en          (rd_en),
    .rd_addr        (rd_addr),
    .stat           (scan_stat)
  );

  // saturating score update
  assign first_sum  = csdc_pkg::score_sum_t'(first_total) +
                      csdc_pkg::score_sum_t'(scan_stat.first_gain);
  assign second_sum = csdc_pkg::score_sum_t'(second_total) +
                      csdc_pkg::score_sum_t'(scan_stat.second_gain);
  assign first_total_next  = first_sum[csdc_pkg::SCORE_W] ? csdc_pkg::SCORE_MAX
                                                          : first_sum[csdc_pkg::SCORE_W-1:0];
  assign second_total_next = second_sum[csdc_pkg::SCORE_W] ? csdc_pkg::SCORE_MAX
                                                           : second_sum[csdc_pkg::SCORE_W-1:0];

  // history append
  assign full       = (stored_count == csdc_pkg::count_t'(csdc_pkg::HISTORY_DEPTH));
  assign count_next = full ? stored_count : stored_count + csdc_pkg::count_t'(1);
  assign wr_en      = commit && !full;

  csdc_ram #(
    .WIDTH (csdc_pkg::VALUE_BITS),
    .DEPTH (csdc_pkg::HISTORY_DEPTH)
  ) u_first_hist (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (stored_count[csdc_pkg::ADDR_W-1:0]),
    .wr_data (first_value),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (first_rd_data)
  );

  csdc_ram #(
    .WIDTH (csdc_pkg::VALUE_BITS),
    .DEPTH (csdc_pkg::HISTORY_DEPTH)
  ) u_second_hist (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (stored_count[csdc_pkg::ADDR_W-1:0]),
    .wr_data (second_value),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (second_rd_data)
  );

  // game state
  always_ff @(posedge clk) begin
    if (rst) begin
      stored_count <= '0;
      first_total  <= '0;
      second_total <= '0;
    end else if (commit) begin
      if (last_round) begin
        stored_count <= '0;
        first_total  <= '0;
        second_total <= '0;
      end else begin
        stored_count <= count_next;
        first_total  <= first_total_next;
        second_total <= second_total_next;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_item.first_score  <= first_total_next;
      out_item.second_score <= second_total_next;
      out_item.rounds_seen  <= csdc_pkg::rounds_t'(count_next);
      out_item.history_full <= full;
      out_item.final_res    <= last_round;
    end
  end

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    stored_count <= csdc_pkg::count_t'(csdc_pkg::HISTORY_DEPTH))
    else $error("stored count beyond history depth");

  a_no_rw_overlap: assert property (@(posedge clk) disable iff (rst)
    !(rd_en && wr_en))
    else $error("history read and write in the same cycle");

  a_done_in_scan: assert property (@(posedge clk) disable iff (rst)
    scan_stat.done |-> (state == S_SCAN))
    else $error("scan done outside scan state");

  a_result_from_update: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_UPDATE))
    else $error("result raised without an update");

endmodule

`default_nettype wire
